// File: hdl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and codes for the Huffman tree byte decoder.
// ----------------------------------------------------------------------------
package htd_pkg;

   // func codes of an input word
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_BYTE  = 2'd2;

   // branch words below this are literal bytes
   localparam int LITERAL_LIMIT = 256;

   // input word
   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  node_index;
      logic        branch;
      logic [15:0] entry_value;
      logic [23:0] expanded_length;
      logic [7:0]  data_byte;
   } req_type;

   // result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rsp_type;

   // command word from front to back, only commands that have an effect
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  node_index;
      logic        branch;
      logic [15:0] entry_value;
      logic [23:0] expanded_length;
      logic [7:0]  data_byte;
   } cmd_type;

endpackage

// File: hdl/htd_ram.sv
// ----------------------------------------------------------------------------
// htd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 510
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/htd_fifo.sv
// ----------------------------------------------------------------------------
// htd_fifo
// Small ready/valid queue.
// ----------------------------------------------------------------------------
module htd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/htd_front.sv
// ----------------------------------------------------------------------------
// htd_front
// Accepts input words, drops those without effect, queues the rest.
// ----------------------------------------------------------------------------
module htd_front #(
   parameter int NODE_COUNT = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  htd_pkg::req_type req,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output htd_pkg::cmd_type cmd
);

   localparam int CMD_BITS = $bits(htd_pkg::cmd_type);

   logic                keep;
   logic                push_ready;
   htd_pkg::cmd_type    cmd_word;
   logic [CMD_BITS-1:0] pop_bits;

   // out-of-range loads and the unused func code are consumed and dropped
   always_comb begin
      unique case (req.func)
         htd_pkg::FUNC_LOAD:  keep = ({1'b0, req.node_index} < 9'(NODE_COUNT));
         htd_pkg::FUNC_START: keep = 1'b1;
         htd_pkg::FUNC_BYTE:  keep = 1'b1;
         default:             keep = 1'b0;
      endcase
   end

   always_comb begin
      cmd_word.op              = req.func;
      cmd_word.node_index      = req.node_index;
      cmd_word.branch          = req.branch;
      cmd_word.entry_value     = req.entry_value;
      cmd_word.expanded_length = req.expanded_length;
      cmd_word.data_byte       = req.data_byte;
   end

   assign req_ready = push_ready;

   htd_fifo #(
      .WIDTH (CMD_BITS),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid && keep),
      .push_ready (push_ready),
      .push_data  (cmd_word),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_data   (pop_bits)
   );

   assign cmd = htd_pkg::cmd_type'(pop_bits);

endmodule

// File: hdl/htd_back.sv
// ----------------------------------------------------------------------------
// htd_back
// Executes commands: tree loads, chunk starts and bit-serial tree walks.
// ----------------------------------------------------------------------------
module htd_back #(
   parameter int NODE_COUNT  = 255,
   parameter int LENGTH_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  htd_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output htd_pkg::rsp_type rsp
);

   localparam int NODE_BITS = $clog2(NODE_COUNT);
   localparam int ADDR_BITS = NODE_BITS + 1;
   localparam int DEPTH     = 2 * NODE_COUNT;
   localparam int RSP_BITS  = $bits(htd_pkg::rsp_type);
   localparam logic [NODE_BITS-1:0] HEAD_NODE = NODE_BITS'(NODE_COUNT - 1);
   localparam logic [16:0] BAD_LIMIT = 17'(htd_pkg::LITERAL_LIMIT + NODE_COUNT);

   logic                   walk_ff, walk_in;
   logic                   active_ff, active_in;
   logic [NODE_BITS-1:0]   node_ff, node_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [2:0]             bit_ff, bit_in;
   logic [7:0]             data_ff, data_in;

   logic [15:0]            word;
   logic                   wr_en, rd_en;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic                   is_lit, is_bad;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic [LENGTH_BITS-1:0] start_len;
   logic                   step_go, walk_end, res_ready, res_push;
   htd_pkg::rsp_type       res_word;
   logic [RSP_BITS-1:0]    res_bits;

   htd_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({cmd.node_index[NODE_BITS-1:0], cmd.branch}),
      .wr_data (cmd.entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (word)
   );

   assign is_lit    = (word[15:8] == 8'd0);
   assign is_bad    = !is_lit && ({1'b0, word} >= BAD_LIMIT);
   assign rem_dec   = rem_ff - LENGTH_BITS'(1);
   assign start_len = LENGTH_BITS'(cmd.expanded_length);

   // hold the walk (and the RAM read data) while the result buffer is full
   assign step_go = walk_ff && !((is_lit || is_bad) && !res_ready);

   always_comb begin
      node_in   = node_ff;
      rem_in    = rem_ff;
      active_in = active_ff;
      walk_in   = walk_ff;
      bit_in    = bit_ff;
      data_in   = data_ff;
      rd_en     = 1'b0;
      rd_addr   = {node_ff, 1'b0};
      wr_en     = 1'b0;
      walk_end  = 1'b0;
      res_push  = 1'b0;
      res_word.out_byte = is_lit ? word[7:0] : 8'd0;
      res_word.last     = is_lit && (rem_dec == '0);
      res_word.error    = is_bad;

      if (step_go) begin
         bit_in = bit_ff + 3'd1;
         if (is_lit) begin
            res_push = 1'b1;
            rem_in   = rem_dec;
            node_in  = HEAD_NODE;
            if (rem_dec == '0) begin
               active_in = 1'b0;
               walk_end  = 1'b1;
            end else begin
               walk_end = (bit_ff == 3'd7);
            end
         end else if (is_bad) begin
            res_push  = 1'b1;
            active_in = 1'b0;
            rem_in    = '0;
            node_in   = HEAD_NODE;
            walk_end  = 1'b1;
         end else begin
            node_in  = word[NODE_BITS-1:0];
            walk_end = (bit_ff == 3'd7);
         end
         if (walk_end) begin
            walk_in = 1'b0;
         end else begin
            rd_en   = 1'b1;
            rd_addr = {node_in, data_ff[bit_in]};
         end
      end

      // next command may start in the cycle the walk finishes
      cmd_ready = !walk_ff || walk_end;
      if (cmd_valid && cmd_ready) begin
         unique case (cmd.op)
            htd_pkg::FUNC_LOAD: begin
               wr_en = 1'b1;
            end
            htd_pkg::FUNC_START: begin
               rem_in    = start_len;
               node_in   = HEAD_NODE;
               active_in = (start_len != '0);
            end
            htd_pkg::FUNC_BYTE: begin
               if (active_in) begin
                  walk_in = 1'b1;
                  bit_in  = 3'd0;
                  data_in = cmd.data_byte;
                  rd_en   = 1'b1;
                  rd_addr = {node_in, cmd.data_byte[0]};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff   <= 1'b0;
         active_ff <= 1'b0;
         node_ff   <= HEAD_NODE;
         rem_ff    <= '0;
      end else begin
         walk_ff   <= walk_in;
         active_ff <= active_in;
         node_ff   <= node_in;
         rem_ff    <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      data_ff <= data_in;
   end

   htd_fifo #(
      .WIDTH (RSP_BITS),
      .DEPTH (2)
   ) u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_push),
      .push_ready (res_ready),
      .push_data  (res_word),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (res_bits)
   );

   assign rsp = htd_pkg::rsp_type'(res_bits);

endmodule

// File: hdl/huffman_tree_byte_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_byte_decoder
// Huffman decoder over a loaded tree, one compressed bit per unstalled cycle.
// ----------------------------------------------------------------------------
// Words on req carry one of three commands: load one 16-bit branch word of
// a tree node, start a chunk with its decoded length, or bring one
// compressed byte. Each byte is walked through the tree LSB first and
// yields 0 to 8 decoded bytes on rsp; the byte that completes the chunk has
// last set, and a branch to a node outside the table gives one word with
// error set and ends the chunk. The back end carries out a load or start as it
// accepts it; a compressed byte is walked one bit per step, since each step
// reads the next node from the tree RAM (registered read) using the word
// the previous step returned. The next command issues in the cycle the walk
// finishes. A two-word command queue and a two-word result buffer decouple
// both sides; an accepted byte passes the command queue, the tree RAM read
// and the result buffer before its first result word is valid.
// Tree words read before ever being loaded return unknown data.
// ----------------------------------------------------------------------------
module huffman_tree_byte_decoder #(
   parameter int NODE_COUNT  = 255,
   parameter int LENGTH_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  htd_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output htd_pkg::rsp_type rsp
);

   // front to back command channel
   logic             cmd_valid;
   logic             cmd_ready;
   htd_pkg::cmd_type cmd;

   // front: filter and queue commands
   htd_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   // back: tree RAM, walker, result buffer
   htd_back #(
      .NODE_COUNT  (NODE_COUNT),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

// File: hdl/htd_checker.sv
// ----------------------------------------------------------------------------
// htd_checker
// Port-level checks for the Huffman tree byte decoder, bound to the top.
// ----------------------------------------------------------------------------
module htd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input htd_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input htd_pkg::rsp_type rsp
);

   // a stalled result word holds
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("result word changed while stalled");

   // reset empties both queues
   property p_reset_empty;
      @(posedge clock) reset |=> !rsp_valid && req_ready;
   endproperty
   a_reset_empty: assert property (p_reset_empty)
      else $error("queues not empty after reset");

   // an error word carries no byte and does not have last set
   property p_error_word;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp.error |-> !rsp.last && (rsp.out_byte == 8'd0);
   endproperty
   a_error_word: assert property (p_error_word)
      else $error("error word with last or data");

endmodule

bind huffman_tree_byte_decoder htd_checker u_checker (.*);
